// ===== rtl/hsj_pkg.sv =====
// ============================================================================
// hsj_pkg: shared widths, register map and lane status type
// Constants and types common to the Halton jitter top level and its axis
// lanes.
// ============================================================================
package hsj_pkg;

    localparam int FRAME_W    = 32;   // frame_number
    localparam int EXT_W      = 15;   // frame_width / frame_height
    localparam int SCALE_W    = 16;   // jitter_scale, Q4.12
    localparam int SCALE_FRAC = 12;
    localparam int PCOUNT_W   = 11;   // Halton cycle length
    localparam int PHASE_W    = 12;   // phase = mod + 1, up to 2047
    localparam int DIG_W      = 12;   // base-3 reverse / denominator, up to 3^7
    localparam int OUT_W      = 29;   // jitter_x / jitter_y
    localparam int M_DATA_W   = ((2 * OUT_W + 7) / 8) * 8;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // n / 3 as (n * 1366) >> 12, exact for n <= 2047
    localparam int RECIP3    = 1366;
    localparam int RECIP3_W  = 11;
    localparam int RECIP3_SH = 12;

    localparam logic [EXT_W-1:0]    RST_WIDTH  = 15'd1920;
    localparam logic [EXT_W-1:0]    RST_HEIGHT = 15'd1080;
    localparam logic [SCALE_W-1:0]  RST_SCALE  = 16'd4096;
    localparam logic [PCOUNT_W-1:0] RST_PCOUNT = 11'd8;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_SCALE  = 2'd2,
        REG_PCOUNT = 2'd3
    } hsj_reg_t;

    typedef struct packed {
        logic             busy;
        logic [OUT_W-1:0] value;
    } hsj_lane_t;

endpackage

// ===== rtl/hsj_axis.sv =====
// ============================================================================
// hsj_axis: one jitter axis
// Offset from one half, bit-serial multiply by scale, bit-serial restoring
// divide by the extent, sign restore.
// ============================================================================
module hsj_axis
    import hsj_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [FRAC_BITS-1:0] radinv,
    input  logic [EXT_W-1:0]     extent,
    input  logic [SCALE_W-1:0]   scale,
    output hsj_lane_t            lane
);

    localparam int PROD_W = FRAC_BITS + SCALE_W;
    // (prod * 2) >> 12 keeps the top PROD_W - 11 bits
    localparam int QUO_W  = PROD_W - (SCALE_FRAC - 1);
    localparam int CNT_W  = $clog2(QUO_W);
    localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS - 1){1'b0}}};

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL,
        L_LOAD,
        L_DIV,
        L_SIGN
    } lane_state_t;

    lane_state_t          state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 neg_reg;
    logic [PROD_W-1:0]    mcand_reg;
    logic [SCALE_W-1:0]   mplier_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [EXT_W-1:0]     rem_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [OUT_W-1:0]     value_reg;

    logic                 in_neg;
    logic [FRAC_BITS-1:0] in_mag;
    logic [EXT_W:0]       div_trial;
    logic                 div_ge;
    logic [EXT_W:0]       div_diff;
    logic [OUT_W-1:0]     quo_out;

    assign in_neg    = radinv < HALF;
    assign in_mag    = in_neg ? (HALF - radinv) : (radinv - HALF);
    assign div_trial = {rem_reg, quo_reg[QUO_W-1]};
    assign div_ge    = div_trial >= {1'b0, extent};
    assign div_diff  = div_trial - {1'b0, extent};
    assign quo_out   = OUT_W'(quo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
        end else begin
            unique case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        neg_reg    <= in_neg;
                        mcand_reg  <= PROD_W'(in_mag);
                        mplier_reg <= scale;
                        acc_reg    <= '0;
                        cnt_reg    <= '0;
                        state_reg  <= L_MUL;
                    end
                end
                L_MUL: begin
                    // LSB-first shift-add, one scale bit per cycle
                    if (mplier_reg[0]) begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(SCALE_W - 1)) begin
                        state_reg <= L_LOAD;
                    end
                end
                L_LOAD: begin
                    quo_reg   <= acc_reg[PROD_W-1 -: QUO_W];
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= L_DIV;
                end
                L_DIV: begin
                    // restoring divide; quotient bits shift in behind the dividend
                    rem_reg <= div_ge ? div_diff[EXT_W-1:0] : div_trial[EXT_W-1:0];
                    quo_reg <= {quo_reg[QUO_W-2:0], div_ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                        state_reg <= L_SIGN;
                    end
                end
                L_SIGN: begin
                    value_reg <= neg_reg ? (~quo_out + OUT_W'(1)) : quo_out;
                    state_reg <= L_IDLE;
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign lane.busy  = state_reg != L_IDLE;
    assign lane.value = value_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == L_IDLE)
        else $error("axis start while busy");

    a_busy_from_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != L_IDLE && $past(state_reg) == L_IDLE) |-> $past(start))
        else $error("axis left idle without start");

    a_mul_consumed: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == L_LOAD |-> mplier_reg == '0)
        else $error("multiplier bits not fully consumed");

endmodule

// ===== rtl/halton_subpixel_jitter.sv =====
// ============================================================================
// halton_subpixel_jitter: Halton (2,3) sub-pixel jitter generator
// Frame number in, NDC jitter pair out, digit-serial datapath.
// ============================================================================
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  s_      | in        | s_tvalid / s_tready   | frame_number
//  m_      | out       | m_tvalid / m_tready   | jitter_x, jitter_y
//  APB     | in/out    | psel, penable, pready | frame_width, frame_height,
//          |           |                       | jitter_scale, cycle length
//
//  Per item: the 32-step serial modulo, k base-3 digit steps (k = number of
//    base-3 digits of the phase, 1..7), the FRAC_BITS-step base-3 fraction
//    divide and the y lane's 16-step multiply plus (FRAC_BITS + 5)-step
//    divide.
//  Zero width, height or cycle length: the item skips the modulo and lane
//    work and goes straight to the output register with both fields zero.
//  Reset: aresetn synchronous, active low; registers return to 1920, 1080,
//    4096 and 8. No clearing pass.
//  Stalls: the result waits in the m_ output register; s_tready is high only
//    while the sequencer is idle, and a finished item waits for that register.
//
module halton_subpixel_jitter
    import hsj_pkg::*;
#(
    parameter int FRAC_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [FRAME_W-1:0]    s_tdata,    // [31:0] frame_number

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,    // [28:0] jitter_x, [57:29] jitter_y, zero pad

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W = $clog2(FRAME_W > FRAC_BITS ? FRAME_W : FRAC_BITS);

    typedef enum logic [2:0] {
        S_IDLE,   // wait for a frame number
        S_MOD,    // frame mod cycle length, one bit per cycle
        S_DIG,    // base-3 digits of the phase, one per cycle
        S_H3,     // reverse / 3^k as FRAC_BITS fraction bits, one per cycle
        S_WAIT,   // axis lanes scale and divide
        S_OUT     // load the output register
    } state_t;

    state_t               state_reg;
    logic [EXT_W-1:0]     width_reg;
    logic [EXT_W-1:0]     height_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic [PCOUNT_W-1:0]  pcount_reg;

    logic [FRAME_W-1:0]   fr_reg;      // dividend shifts out MSB first
    logic [PCOUNT_W-1:0]  mrem_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIG_W-1:0]     n_reg;       // phase left to split into digits
    logic [DIG_W-1:0]     rev_reg;     // digit reverse, then fraction remainder
    logic [DIG_W-1:0]     den_reg;     // 3^k
    logic [FRAC_BITS-1:0] h3_reg;      // base-3 radical inverse
    logic [FRAC_BITS-1:0] r2_reg;      // base-2 radical inverse
    logic                 start_x_reg;
    logic                 start_y_reg;
    logic                 zero_reg;
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;

    logic                 cfg_wr;
    logic                 cfg_zero;
    logic                 out_load;
    logic [PCOUNT_W:0]    mod_trial;
    logic                 mod_ge;
    logic [PCOUNT_W:0]    mod_diff;
    logic [PCOUNT_W-1:0]  mod_rem_next;
    logic [PHASE_W-1:0]   phase;
    logic [FRAC_BITS-1:0] r2_w;
    logic [DIG_W+RECIP3_W-1:0] dig_prod;
    logic [DIG_W-1:0]     dig_q;
    logic [1:0]           dig_d;
    logic [DIG_W:0]       h3_trial;
    logic                 h3_ge;
    logic [DIG_W:0]       h3_diff;
    hsj_lane_t            lane_x;
    hsj_lane_t            lane_y;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_zero = (width_reg == '0) || (height_reg == '0) || (pcount_reg == '0);

    always_comb begin
        unique case (hsj_reg_t'(paddr[3:2]))
            REG_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_HEIGHT: prdata = APB_DATA_W'(height_reg);
            REG_SCALE:  prdata = APB_DATA_W'(scale_reg);
            REG_PCOUNT: prdata = APB_DATA_W'(pcount_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------- phase: serial restoring modulo ----------------
    assign mod_trial    = {mrem_reg, fr_reg[FRAME_W-1]};
    assign mod_ge       = mod_trial >= {1'b0, pcount_reg};
    assign mod_diff     = mod_trial - {1'b0, pcount_reg};
    assign mod_rem_next = mod_ge ? mod_diff[PCOUNT_W-1:0] : mod_trial[PCOUNT_W-1:0];
    assign phase        = PHASE_W'(mod_rem_next) + PHASE_W'(1);

    // base 2: radical inverse is the phase bits mirrored below the binary point
    always_comb begin
        r2_w = '0;
        for (int i = 0; i < PHASE_W; i++) begin
            r2_w[FRAC_BITS-1-i] = phase[i];
        end
    end

    // ---------------- base 3 digits ----------------
    assign dig_prod = (DIG_W + RECIP3_W)'(n_reg) * (DIG_W + RECIP3_W)'(RECIP3);
    assign dig_q    = DIG_W'(dig_prod >> RECIP3_SH);
    assign dig_d    = 2'(n_reg - dig_q - dig_q - dig_q);

    // fraction bits of reverse / 3^k
    assign h3_trial = {rev_reg, 1'b0};
    assign h3_ge    = h3_trial >= {1'b0, den_reg};
    assign h3_diff  = h3_trial - {1'b0, den_reg};

    // output register takes a finished item when empty or being emptied
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            width_reg    <= RST_WIDTH;
            height_reg   <= RST_HEIGHT;
            scale_reg    <= RST_SCALE;
            pcount_reg   <= RST_PCOUNT;
            start_x_reg  <= 1'b0;
            start_y_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // x lane runs under the base-3 work
            start_x_reg <= (state_reg == S_MOD) && (cnt_reg == CNT_W'(FRAME_W - 1));
            start_y_reg <= (state_reg == S_H3) && (cnt_reg == CNT_W'(FRAC_BITS - 1));

            if (cfg_wr) begin
                unique case (hsj_reg_t'(paddr[3:2]))
                    REG_WIDTH:  width_reg  <= pwdata[EXT_W-1:0];
                    REG_HEIGHT: height_reg <= pwdata[EXT_W-1:0];
                    REG_SCALE:  scale_reg  <= pwdata[SCALE_W-1:0];
                    REG_PCOUNT: pcount_reg <= pwdata[PCOUNT_W-1:0];
                    default:    ;
                endcase
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        fr_reg    <= s_tdata;
                        mrem_reg  <= '0;
                        cnt_reg   <= '0;
                        zero_reg  <= cfg_zero;
                        state_reg <= cfg_zero ? S_OUT : S_MOD;
                    end
                end
                S_MOD: begin
                    fr_reg   <= fr_reg << 1;
                    mrem_reg <= mod_rem_next;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(FRAME_W - 1)) begin
                        n_reg     <= DIG_W'(phase);
                        rev_reg   <= '0;
                        den_reg   <= DIG_W'(1);
                        r2_reg    <= r2_w;
                        state_reg <= S_DIG;
                    end
                end
                S_DIG: begin
                    if (n_reg == '0) begin
                        cnt_reg   <= '0;
                        state_reg <= S_H3;
                    end else begin
                        n_reg   <= dig_q;
                        rev_reg <= DIG_W'({rev_reg, 1'b0} + rev_reg + dig_d);
                        den_reg <= DIG_W'({den_reg, 1'b0} + den_reg);
                    end
                end
                S_H3: begin
                    rev_reg <= h3_ge ? h3_diff[DIG_W-1:0] : h3_trial[DIG_W-1:0];
                    h3_reg  <= {h3_reg[FRAC_BITS-2:0], h3_ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(FRAC_BITS - 1)) begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (!start_y_reg && !lane_x.busy && !lane_y.busy) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        m_tdata_reg <= zero_reg ? '0
                                       : M_DATA_W'({lane_y.value, lane_x.value});
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- axis lanes ----------------
    hsj_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_x_reg),
        .radinv  (r2_reg),
        .extent  (width_reg),
        .scale   (scale_reg),
        .lane    (lane_x)
    );

    hsj_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_y_reg),
        .radinv  (h3_reg),
        .extent  (height_reg),
        .scale   (scale_reg),
        .lane    (lane_y)
    );

    a_idle_lanes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !lane_x.busy && !lane_y.busy)
        else $error("axis lane busy while sequencer idle");

    a_h3_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_H3 |-> rev_reg < den_reg)
        else $error("base-3 fraction remainder out of range");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg)) |-> $past(state_reg) == S_OUT)
        else $error("result transfer raised outside output state");

endmodule

// ===== bench/tb_halton_subpixel_jitter.sv =====
// ============================================================================
// tb_halton_subpixel_jitter: self-checking bench for the Halton jitter block
// Streams frame numbers into the block under several register settings, with
// random idling on both stream sides. Every jitter pair is compared with the
// value computed in the bench from the same registers.
// ============================================================================
module tb_halton_subpixel_jitter;
    import hsj_pkg::*;

    localparam int JIT_FRAC    = 24;    // fraction bits of the jitter datapath
    localparam int STALL_LIMIT = 5000;  // cycles without any transfer
    localparam int DRAIN_WAIT  = 200;   // covers one full item
    localparam int PHASE_ITEMS = 250;   // random items per register setting
    localparam int NUM_PHASES  = 7;

    // expected jitter pair, tagged with the frame that produced it
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [OUT_W-1:0]   x;
        logic [OUT_W-1:0]   y;
    } jitter_pair_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [FRAME_W-1:0]    s_tdata  = '0;   // [31:0] frame_number

    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;         // [28:0] jitter_x, [57:29] jitter_y, pad

    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // bench copy of the register file
    logic [EXT_W-1:0]      cfg_width  = RST_WIDTH;
    logic [EXT_W-1:0]      cfg_height = RST_HEIGHT;
    logic [SCALE_W-1:0]    cfg_scale  = RST_SCALE;
    logic [PCOUNT_W-1:0]   cfg_pcount = RST_PCOUNT;

    logic [FRAME_W-1:0]    frame_q[$];      // frames waiting to be sent
    jitter_pair_t          jitter_q[$];     // pairs owed by the block

    int unsigned           send_idle_pct = 17;
    int unsigned           recv_idle_pct = 45;
    int unsigned           err_count     = 0;
    int unsigned           quiet_cycles  = 0;

    always #2 aclk = ~aclk;

    halton_subpixel_jitter #(
        .FRAC_BITS (JIT_FRAC)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // Jitter prediction
    // ------------------------------------------------------------------------

    // floor(radical inverse of n in the given base * 2^JIT_FRAC)
    function automatic logic [63:0] radical_inverse_fixed(input logic [PHASE_W-1:0] n,
                                                          input int unsigned base);
        logic [63:0]        rev;
        logic [63:0]        den;
        logic [PHASE_W-1:0] k;
        rev = 64'd0;
        den = 64'd1;
        k   = n;
        while (k != 0) begin
            rev = rev * base + (k % base);
            k   = k / base;
            den = den * base;
        end
        return (rev << JIT_FRAC) / den;
    endfunction

    // (r - 1/2) * scale * 2 / extent, truncated toward zero, wrapped to OUT_W
    function automatic logic [OUT_W-1:0] ndc_offset(input logic [63:0] r,
                                                    input logic [EXT_W-1:0] extent);
        logic [63:0] half;
        logic [63:0] mag;
        logic [63:0] q;
        logic        neg;
        half = 64'd1 << (JIT_FRAC - 1);
        neg  = r < half;
        mag  = neg ? (half - r) : (r - half);
        q    = (mag * 64'(cfg_scale) * 64'd2) / (64'(extent) << SCALE_FRAC);
        if (neg) begin
            q = 64'd0 - q;
        end
        return q[OUT_W-1:0];
    endfunction

    function automatic jitter_pair_t predict_jitter(input logic [FRAME_W-1:0] frame);
        jitter_pair_t       p;
        logic [PHASE_W-1:0] phase;
        p.frame = frame;
        p.x     = '0;
        p.y     = '0;
        // any zero extent or an empty cycle forces zero jitter
        if (cfg_width != 0 && cfg_height != 0 && cfg_pcount != 0) begin
            phase = PHASE_W'(frame % cfg_pcount + 32'd1);
            p.x   = ndc_offset(radical_inverse_fixed(phase, 2), cfg_width);
            p.y   = ndc_offset(radical_inverse_fixed(phase, 3), cfg_height);
        end
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Stream driver: next frame goes out once the current one is transferred
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (frame_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= frame_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input transfer, check on result transfer, watchdog
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        jitter_pair_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                jitter_q.push_back(predict_jitter(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (jitter_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("unexpected result: x=%h y=%h",
                                 m_tdata[OUT_W-1:0], m_tdata[2*OUT_W-1:OUT_W]);
                    end
                end else begin
                    want = jitter_q.pop_front();
                    if (m_tdata[OUT_W-1:0] !== want.x ||
                        m_tdata[2*OUT_W-1:OUT_W] !== want.y ||
                        m_tdata[M_DATA_W-1:2*OUT_W] !== '0) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("mismatch frame %h: exp x=%h y=%h got x=%h y=%h pad=%h",
                                     want.frame, want.x, want.y,
                                     m_tdata[OUT_W-1:0], m_tdata[2*OUT_W-1:OUT_W],
                                     m_tdata[M_DATA_W-1:2*OUT_W]);
                        end
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Register access: setup cycle, then access cycle until pready
    // ------------------------------------------------------------------------
    task automatic reg_write(input hsj_reg_t idx, input logic [APB_DATA_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << 2;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_width  = val[EXT_W-1:0];
            REG_HEIGHT: cfg_height = val[EXT_W-1:0];
            REG_SCALE:  cfg_scale  = val[SCALE_W-1:0];
            REG_PCOUNT: cfg_pcount = val[PCOUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [APB_DATA_W-1:0] w, input logic [APB_DATA_W-1:0] h,
                             input logic [APB_DATA_W-1:0] s, input logic [APB_DATA_W-1:0] pc);
        reg_write(REG_WIDTH,  w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_SCALE,  s);
        reg_write(REG_PCOUNT, pc);
    endtask

    // block is idle: nothing queued, nothing in flight, nothing owed
    task automatic wait_drained();
        do @(negedge aclk);
        while (frame_q.size() != 0 || s_tvalid || jitter_q.size() != 0);
    endtask

    // mix of full-range frames, small frames and frames at cycle boundaries
    task automatic queue_random_frames(input int unsigned count);
        logic [FRAME_W-1:0] f;
        repeat (count) begin
            case ($urandom_range(3, 0))
                0, 1:    f = $urandom;
                2:       f = $urandom_range(4095, 0);
                default: f = 32'(cfg_pcount) * $urandom_range(100000, 0)
                             + ($urandom_range(1, 0) ? 32'(cfg_pcount) - 32'd1 : 32'd0);
            endcase
            frame_q.push_back(f);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned ph;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset register values, one full 8-phase cycle plus frame extremes
        for (int unsigned f = 0; f < 8; f++) begin
            frame_q.push_back(f);
        end
        frame_q.push_back(32'hFFFF_FFFF);
        frame_q.push_back(32'h8000_0000);
        frame_q.push_back(32'h7FFF_FFFF);
        wait_drained();

        // largest amplitude, longest cycle: phase 2047 has the most base-3 digits
        configure(32'd1, 32'd1, 32'd65535, 32'd2047);
        @(negedge aclk);
        frame_q.push_back(32'd2046);
        frame_q.push_back(32'd0);
        frame_q.push_back(32'd1023);
        frame_q.push_back(32'hFFFF_FFFF);
        wait_drained();

        // zero width, zero height, empty cycle, zero amplitude
        reg_write(REG_WIDTH, 32'd0);
        @(negedge aclk);
        frame_q.push_back(32'd5);
        frame_q.push_back(32'hFFFF_FFFF);
        wait_drained();
        reg_write(REG_WIDTH, 32'd1);
        reg_write(REG_HEIGHT, 32'd0);
        @(negedge aclk);
        frame_q.push_back(32'd6);
        frame_q.push_back(32'h1234_5678);
        wait_drained();
        reg_write(REG_HEIGHT, 32'd1);
        reg_write(REG_PCOUNT, 32'd0);
        @(negedge aclk);
        frame_q.push_back(32'd7);
        frame_q.push_back(32'hFFFF_FFFF);
        wait_drained();
        reg_write(REG_PCOUNT, 32'd2047);
        reg_write(REG_SCALE, 32'd0);
        @(negedge aclk);
        frame_q.push_back(32'd3);
        frame_q.push_back(32'd2046);
        wait_drained();

        // random part, one register setting per phase
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: configure($urandom_range(16384, 1), $urandom_range(16384, 1),
                             $urandom_range(65535, 0), $urandom_range(1024, 1));
                1: configure(32'd1, 32'd1, 32'd65535, 32'd1024);
                2: configure(32'd16384, 32'd16384, 32'd1, 32'd1);
                // above the stated ranges: full register width is used
                3: configure(32'd32767, $urandom_range(32767, 1),
                             $urandom_range(65535, 0), 32'd2047);
                // zero height: short path under swapped idling
                4: configure($urandom_range(16384, 1), 32'd0,
                             $urandom_range(65535, 0), $urandom_range(1024, 1));
                // raw bus words, the block keeps only the register bits
                5: configure($urandom, $urandom, $urandom, $urandom);
                default: configure($urandom_range(16384, 1), $urandom_range(16384, 1),
                                   $urandom_range(65535, 0), $urandom_range(16, 1));
            endcase
            @(negedge aclk);
            // idling: sender 17 / receiver 45, then swapped, then none
            if (ph < 3) begin
                send_idle_pct = 17;
                recv_idle_pct = 45;
            end else if (ph < 5) begin
                send_idle_pct = 45;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // halfway through, the sender holds off until the block has drained
            queue_random_frames(PHASE_ITEMS / 2);
            wait_drained();
            queue_random_frames(PHASE_ITEMS - PHASE_ITEMS / 2);
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_count == 0 && jitter_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hsj_pkg.sv
rtl/hsj_axis.sv
rtl/halton_subpixel_jitter.sv
bench/tb_halton_subpixel_jitter.sv
